>>> src/aes_pkg.sv
// Shared types, S-box tables and round functions for the AES-128 CBC cipher.
package aes_pkg;

  localparam int NumRounds = 10;
  localparam int RkDepth   = 2 * (NumRounds + 1);
  localparam int RkAddrW   = 5;
  localparam int RoundW    = 4;

  localparam logic [2:0] CfgMode  = 3'd0;
  localparam logic [2:0] CfgKeyHi = 3'd1;
  localparam logic [2:0] CfgKeyLo = 3'd2;
  localparam logic [2:0] CfgIvHi  = 3'd3;
  localparam logic [2:0] CfgIvLo  = 3'd4;

  typedef struct packed {
    logic [63:0] block_hi;
    logic [63:0] block_lo;
    logic        chain_start;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [63:0] data;
  } cfg_req_t;

  // Control from the sequencer to the round datapath.
  typedef struct packed {
    logic              load;
    logic              step;
    logic              last;
    logic              decrypt;
  } rnd_ctrl_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
      8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
      8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
      8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
      8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
      8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
      8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
      8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
      8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
      8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
      8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
      8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
      8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
      8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
      8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};
    return t[x];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
  endfunction

  // Byte k of a 128-bit state, byte 0 in the top bits.
  function automatic logic [7:0] get_byte(input logic [127:0] s, input int k);
    return s[127 - 8 * k -: 8];
  endfunction

  // One forward round without the key addition; the last round leaves out the mix.
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [127:0] sr;
    logic [127:0] mc;
    logic [7:0]   a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[127 - 8 * (4 * c + r) -: 8] = sbox(get_byte(s, 4 * ((c + r) % 4) + r));
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(sr, 4 * c);
      a1 = get_byte(sr, 4 * c + 1);
      a2 = get_byte(sr, 4 * c + 2);
      a3 = get_byte(sr, 4 * c + 3);
      mc[127 - 8 * (4 * c) -: 8]     = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      mc[127 - 8 * (4 * c + 1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      mc[127 - 8 * (4 * c + 2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      mc[127 - 8 * (4 * c + 3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    return last ? sr : mc;
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] m);
    logic [7:0] a2, a4, a8;
    a2 = xt(a);
    a4 = xt(a2);
    a8 = xt(a4);
    return (m[0] ? a : 8'h00) ^ (m[1] ? a2 : 8'h00) ^ (m[2] ? a4 : 8'h00) ^
           (m[3] ? a8 : 8'h00);
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] mc;
    logic [7:0]   a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4 * c);
      a1 = get_byte(s, 4 * c + 1);
      a2 = get_byte(s, 4 * c + 2);
      a3 = get_byte(s, 4 * c + 3);
      mc[127 - 8 * (4 * c) -: 8] =
        gmul(a0, 4'd14) ^ gmul(a1, 4'd11) ^ gmul(a2, 4'd13) ^ gmul(a3, 4'd9);
      mc[127 - 8 * (4 * c + 1) -: 8] =
        gmul(a0, 4'd9) ^ gmul(a1, 4'd14) ^ gmul(a2, 4'd11) ^ gmul(a3, 4'd13);
      mc[127 - 8 * (4 * c + 2) -: 8] =
        gmul(a0, 4'd13) ^ gmul(a1, 4'd9) ^ gmul(a2, 4'd14) ^ gmul(a3, 4'd11);
      mc[127 - 8 * (4 * c + 3) -: 8] =
        gmul(a0, 4'd11) ^ gmul(a1, 4'd13) ^ gmul(a2, 4'd9) ^ gmul(a3, 4'd14);
    end
    return mc;
  endfunction

  // Inverse shift and substitution.
  function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127 - 8 * (4 * c + r) -: 8] = inv_sbox(get_byte(s, 4 * ((c + 4 - r) % 4) + r));
      end
    end
    return o;
  endfunction

endpackage

>>> src/aes_key_exp.sv
// Round key expansion: one 128-bit round key per cycle into the key store.
module aes_key_exp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [127:0]                 key,
  input  logic [aes_pkg::RoundW-1:0]   rd_round,
  output logic [127:0]                 rd_key,
  output logic                         busy
);

  logic [127:0]               cur;
  logic [7:0]                 rc;
  logic [aes_pkg::RoundW-1:0] cnt;
  logic [127:0]               nxt;
  logic [31:0]                t;
  logic [31:0]                w0, w1, w2, w3;
  logic [63:0]                store [aes_pkg::RkDepth];
  logic [aes_pkg::RkAddrW-1:0] wa;
  logic [aes_pkg::RkAddrW-1:0] ra;

  // Next round key from the current one.
  always_comb begin
    t  = {aes_pkg::sbox(cur[23:16]) ^ rc, aes_pkg::sbox(cur[15:8]),
          aes_pkg::sbox(cur[7:0]), aes_pkg::sbox(cur[31:24])};
    w0 = cur[127:96] ^ t;
    w1 = cur[95:64] ^ w0;
    w2 = cur[63:32] ^ w1;
    w3 = cur[31:0] ^ w2;
    nxt = {w0, w1, w2, w3};
  end

  // Sequencing of the eleven round keys; round 0 is written at start.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= aes_pkg::RoundW'(1);
      cur  <= key;
      rc   <= 8'h01;
    end else if (busy) begin
      cur <= nxt;
      rc  <= aes_pkg::xt(rc);
      cnt <= cnt + 1'b1;
      if (cnt == aes_pkg::RoundW'(aes_pkg::NumRounds)) begin
        busy <= 1'b0;
      end
    end
  end

  // Store, two 64-bit entries per round, written in two halves per cycle.
  assign wa = {cnt, 1'b0};
  assign ra = {rd_round, 1'b0};
  always_ff @(posedge clk) begin
    if (start) begin
      store[0] <= key[127:64];
      store[1] <= key[63:0];
    end else if (busy) begin
      store[wa]        <= nxt[127:64];
      store[wa | 5'd1] <= nxt[63:0];
    end
    rd_key <= {store[ra], store[ra | 5'd1]};
  end

endmodule

>>> src/aes_round_unit.sv
// Shared round datapath: one cipher round per cycle on the state register while step is set.
module aes_round_unit (
  input  logic                clk,
  input  aes_pkg::rnd_ctrl_t  ctrl,
  input  logic [127:0]        load_val,
  input  logic [127:0]        rkey,
  output logic [127:0]        state
);

  logic [127:0] enc_v;
  logic [127:0] dec_v;

  // Forward: sub, shift, mix then key. Inverse: shift, sub, key then mix. The last round skips the mix.
  always_comb begin
    enc_v = aes_pkg::enc_round(state, ctrl.last) ^ rkey;
    dec_v = aes_pkg::inv_sub_shift(state) ^ rkey;
    if (!ctrl.last) begin
      dec_v = aes_pkg::inv_mix(dec_v);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      state <= load_val ^ rkey;
    end else if (ctrl.step) begin
      state <= ctrl.decrypt ? dec_v : enc_v;
    end
  end

endmodule

>>> src/aes128_cbc_cipher.sv
// Top level of the AES-128 CBC cipher: registers, sequencer and chaining.
//
// Use: write the mode, key and IV on the cfg channel (index 0 mode, 1-2 key,
// 3-4 IV) while the block is idle. Each request on in_* carries one 16-byte
// block; chain_start restarts the chain from the IV. One result block comes
// out on out_* per request, in order.
// Sequence: a request accepted in IDLE goes to PRIME, which loads the initial
// key addition, then ROUND runs the ten rounds on the single round unit, with
// a registered round key read one round ahead; out_valid rises as the last
// round is written. The first request after reset or a key write first waits
// in EXPAND for the key expansion, one round key a cycle. A new block is taken
// only in IDLE: in_ready is low while a block is in work or its result
// waits.
// Reset clears the mode, key, IV and chain to zero and marks the round keys
// stale. When the receiver holds out_ready low, the result stays on out_*
// and no further request is taken.
module aes128_cbc_cipher (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  aes_pkg::cfg_req_t  cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  aes_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output aes_pkg::out_item_t out_item
);

  typedef enum logic [2:0] {
    IDLE, EXPAND, PRIME, ROUND, DONE
  } state_t;

  state_t                     state;
  logic                       decrypt_mode;
  logic [127:0]               key;
  logic [127:0]               iv;
  logic [127:0]               chain;
  logic [127:0]               blk;
  logic                       keys_valid;
  logic                       decrypt;
  logic [aes_pkg::RoundW-1:0] rnd;
  logic                       rd_dec;
  logic [aes_pkg::RoundW-1:0] rd_step;
  logic [aes_pkg::RoundW-1:0] rd_round;
  logic [127:0]               rd_key;
  logic                       kx_busy;
  logic                       kx_start;
  aes_pkg::rnd_ctrl_t         ctrl;
  logic [127:0]               load_val;
  logic [127:0]               rs;
  logic [127:0]               res;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      decrypt_mode <= 1'b0;
      key          <= '0;
      iv           <= '0;
    end else if (cfg_valid) begin
      case (cfg.index)
        aes_pkg::CfgMode:  decrypt_mode <= cfg.data[0];
        aes_pkg::CfgKeyHi: key[127:64]  <= cfg.data;
        aes_pkg::CfgKeyLo: key[63:0]    <= cfg.data;
        aes_pkg::CfgIvHi:  iv[127:64]   <= cfg.data;
        aes_pkg::CfgIvLo:  iv[63:0]     <= cfg.data;
        default: ;
      endcase
    end
  end

  assign kx_start = (state == IDLE) && in_valid && !keys_valid;

  aes_key_exp u_kx (
    .clk      (clk),
    .rst      (rst),
    .start    (kx_start),
    .key      (key),
    .rd_round (rd_round),
    .rd_key   (rd_key),
    .busy     (kx_busy)
  );

  // Round key read address: the first round while waiting to start, then
  // one round ahead of the round unit.
  always_comb begin
    rd_dec  = (state == IDLE) ? decrypt_mode : decrypt;
    rd_step = ((state == PRIME) || (state == ROUND && !ctrl.last)) ? rnd + 1'b1 : '0;
    rd_round = rd_dec ? aes_pkg::RoundW'(aes_pkg::NumRounds) - rd_step : rd_step;
  end

  // Initial whitening input: chained plaintext or ciphertext.
  assign load_val  = decrypt ? blk : (blk ^ chain);
  assign ctrl.load = (state == PRIME);
  assign ctrl.step = (state == ROUND);
  assign ctrl.last = (rnd == aes_pkg::RoundW'(aes_pkg::NumRounds));
  assign ctrl.decrypt = decrypt;

  aes_round_unit u_rnd (
    .clk      (clk),
    .ctrl     (ctrl),
    .load_val (load_val),
    .rkey     (rd_key),
    .state    (rs)
  );

  // The finished state is held in the round unit while the result waits.
  assign res      = decrypt ? (rs ^ chain) : rs;
  assign out_item = '{result_hi: res[127:64], result_lo: res[63:0]};

  // Sequencer; rnd counts the round key in the read register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      keys_valid <= 1'b0;
      chain      <= '0;
      out_valid  <= 1'b0;
      rnd        <= '0;
    end else begin
      if (cfg_valid && (cfg.index == aes_pkg::CfgKeyHi || cfg.index == aes_pkg::CfgKeyLo)) begin
        keys_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            blk     <= {in_item.block_hi, in_item.block_lo};
            decrypt <= decrypt_mode;
            rnd     <= '0;
            if (in_item.chain_start) begin
              chain <= iv;
            end
            state <= keys_valid ? PRIME : EXPAND;
          end
        end
        EXPAND: begin
          if (!kx_busy) begin
            keys_valid <= 1'b1;
            state      <= PRIME;
          end
        end
        PRIME: begin
          // Key of the first round was read during the previous cycle.
          state <= ROUND;
          rnd   <= rnd + 1'b1;
        end
        ROUND: begin
          if (ctrl.last) begin
            state     <= DONE;
            out_valid <= 1'b1;
          end else begin
            rnd <= rnd + 1'b1;
          end
        end
        DONE: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            chain     <= decrypt ? blk : res;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // A result is shown only while the block waits in DONE.
  a_out_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == DONE)
    else $error("result valid outside DONE");

  // The round keys are never used while expansion is running.
  a_no_use_in_expand: assert property (@(posedge clk) disable iff (rst)
    (state == PRIME || state == ROUND) |-> !kx_busy)
    else $error("round key read during expansion");

  // A delivered result returns the block to IDLE.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> state == IDLE && !out_valid)
    else $error("block not idle after delivery");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the AES-128 CBC cipher with random idling on both channels.
`timescale 1ns / 100ps

module testbench;

  localparam logic [2:0] CfgBadIdx = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  aes_pkg::cfg_req_t cfg = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  aes_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  aes_pkg::out_item_t out_item;

  aes128_cbc_cipher u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg(cfg),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  always #10 clk = ~clk;

  // Shadow of the cipher registers and chain.
  logic         sh_decrypt;
  logic [127:0] sh_key;
  logic [127:0] sh_iv;
  logic [127:0] sh_chain;
  logic [127:0] round_keys [11];

  aes_pkg::in_item_t  block_queue [$];
  aes_pkg::out_item_t cipher_queue [$];
  int errors = 0;
  int n_blocks = 0;
  int n_results = 0;
  int n_cfg = 0;
  int cycle = 0;
  int hold_cycles = 0;
  logic hold_req = 1'b0;
  logic cfg_busy = 1'b0;
  aes_pkg::cfg_req_t cfg_pending;

  // Small field arithmetic helpers written out independently of the package.
  function automatic logic [7:0] dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc ^= a;
      a = dbl(a);
    end
    return acc;
  endfunction

  // Forward S-box is computed from the field inverse and affine map.
  function automatic logic [7:0] fwd_s(input logic [7:0] x);
    logic [7:0] inv, y;
    inv = 8'h00;
    for (int c = 1; c < 256; c++)
      if (gf_mult(x, c[7:0]) == 8'h01) inv = c[7:0];
    y = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]} ^
        {inv[3:0], inv[7:4]} ^ 8'h63;
    return y;
  endfunction

  logic [7:0] sfwd [256];
  logic [7:0] sinv [256];

  function automatic logic [7:0] bt(input logic [127:0] s, input int k);
    return s[127 - 8 * k -: 8];
  endfunction

  function automatic void expand_round_keys();
    logic [7:0] w [176];
    logic [7:0] t [4];
    logic [7:0] f, rc;
    rc = 8'h01;
    for (int k = 0; k < 16; k++) w[k] = bt(sh_key, k);
    for (int i = 4; i < 44; i++) begin
      for (int b = 0; b < 4; b++) t[b] = w[4 * (i - 1) + b];
      if (i % 4 == 0) begin
        f = t[0];
        t[0] = sfwd[t[1]] ^ rc;
        t[1] = sfwd[t[2]];
        t[2] = sfwd[t[3]];
        t[3] = sfwd[f];
        rc = dbl(rc);
      end
      for (int b = 0; b < 4; b++) w[4 * i + b] = w[4 * (i - 4) + b] ^ t[b];
    end
    for (int r = 0; r < 11; r++)
      for (int k = 0; k < 16; k++) round_keys[r][127 - 8 * k -: 8] = w[16 * r + k];
  endfunction

  function automatic logic [127:0] shift_sub(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    int src;
    for (int n = 0; n < 4; n++)
      for (int i = 0; i < 4; i++) begin
        src = inv ? ((n + 4 - i) % 4) : ((n + i) % 4);
        o[127 - 8 * (4 * n + i) -: 8] = inv ? sinv[bt(s, 4 * src + i)]
                                            : sfwd[bt(s, 4 * src + i)];
      end
    return o;
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
    logic [7:0] m [4];
    logic [7:0] v;
    logic [127:0] o;
    if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
    else m = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int j = 0; j < 4; j++) v ^= gf_mult(bt(s, 4 * c + j), m[(j - r + 4) % 4]);
        o[127 - 8 * (4 * c + r) -: 8] = v;
      end
    return o;
  endfunction

  // Computes the CBC output of one block and advances the chain.
  function automatic aes_pkg::out_item_t cbc_block(input aes_pkg::in_item_t it);
    logic [127:0] s, d;
    aes_pkg::out_item_t r;
    if (it.chain_start) sh_chain = sh_iv;
    d = {it.block_hi, it.block_lo};
    if (sh_decrypt) begin
      s = d ^ round_keys[10];
      for (int k = 9; k >= 0; k--) begin
        s = shift_sub(s, 1'b1) ^ round_keys[k];
        if (k != 0) s = mix(s, 1'b1);
      end
      s ^= sh_chain;
      sh_chain = d;
    end else begin
      s = (d ^ sh_chain) ^ round_keys[0];
      for (int k = 1; k <= 10; k++) begin
        s = shift_sub(s, 1'b0);
        if (k != 10) s = mix(s, 1'b0);
        s ^= round_keys[k];
      end
      sh_chain = s;
    end
    {r.result_hi, r.result_lo} = s;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s at cycle %0d: got %h expected %h", what, cycle, got, want);
    errors++;
  endtask

  function automatic aes_pkg::in_item_t rand_block(input logic start);
    aes_pkg::in_item_t it;
    it.block_hi = {$urandom, $urandom};
    it.block_lo = {$urandom, $urandom};
    it.chain_start = start;
    return it;
  endfunction

  // Driver: takes requests from the pending queue with random gaps.
  int gap = 0;
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst) begin
      if (in_valid && in_ready) begin
        cipher_queue.push_back(cbc_block(in_item));
        n_blocks <= n_blocks + 1;
      end
      if (!in_valid || in_ready) begin
        if (gap > 0 || block_queue.size() == 0) begin
          in_valid <= 1'b0;
          if (gap > 0) gap <= gap - 1;
        end else begin
          in_item <= block_queue.pop_front();
          in_valid <= 1'b1;
          gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
               : ($urandom_range(0, 2) == 0 ? $urandom_range(0, 3) : 0);
        end
      end
    end
  end

  // Long receiver hold-off, counted in its own process.
  always @(posedge clk) begin
    if (rst) begin
      hold_cycles <= 0;
    end else if (hold_req && hold_cycles == 0) begin
      hold_cycles <= 400;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // Monitor: random receiver stalls, and none taken during the hold-off.
  always @(posedge clk) begin
    aes_pkg::out_item_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        n_results <= n_results + 1;
        if (cipher_queue.size() == 0) begin
          report_mismatch("unexpected result", out_item.result_hi, 64'h0);
        end else begin
          want = cipher_queue.pop_front();
          if (out_item.result_hi !== want.result_hi)
            report_mismatch("result_hi", out_item.result_hi, want.result_hi);
          if (out_item.result_lo !== want.result_lo)
            report_mismatch("result_lo", out_item.result_lo, want.result_lo);
        end
      end
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Register write channel; the shadow follows each accepted write.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg.index)
          aes_pkg::CfgMode:  sh_decrypt = cfg.data[0];
          aes_pkg::CfgKeyHi: begin sh_key[127:64] = cfg.data; expand_round_keys(); end
          aes_pkg::CfgKeyLo: begin sh_key[63:0] = cfg.data; expand_round_keys(); end
          aes_pkg::CfgIvHi:  sh_iv[127:64] = cfg.data;
          aes_pkg::CfgIvLo:  sh_iv[63:0] = cfg.data;
          default: ;
        endcase
        n_cfg <= n_cfg + 1;
        cfg_valid <= 1'b0;
        cfg_busy <= 1'b0;
      end else if (cfg_busy && !cfg_valid) begin
        cfg <= cfg_pending;
        cfg_valid <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_pending = '{index: idx, data: val};
    cfg_busy = 1'b1;
    while (cfg_busy) @(posedge clk);
  endtask

  // Wait until the pending queue drains and every result has come back.
  task automatic drain();
    while (block_queue.size() != 0 || in_valid || cipher_queue.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic setup(input logic mode, input logic [127:0] key, input logic [127:0] iv);
    write_reg(aes_pkg::CfgMode, {63'b0, mode});
    write_reg(aes_pkg::CfgKeyHi, key[127:64]);
    write_reg(aes_pkg::CfgKeyLo, key[63:0]);
    write_reg(aes_pkg::CfgIvHi, iv[127:64]);
    write_reg(aes_pkg::CfgIvLo, iv[63:0]);
  endtask

  // Timeout guard.
  always @(posedge clk) begin
    if (cycle > 2000000) begin
      $display("timeout at cycle %0d", cycle);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int len;
    for (int x = 0; x < 256; x++) sfwd[x] = fwd_s(x[7:0]);
    for (int x = 0; x < 256; x++) sinv[sfwd[x]] = x[7:0];
    sh_decrypt = 1'b0;
    sh_key = '0;
    sh_iv = '0;
    sh_chain = '0;
    expand_round_keys();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero key after reset and no chain start, so the chain is zero.
    block_queue.push_back(aes_pkg::in_item_t'{64'h0, 64'h0, 1'b0});
    block_queue.push_back(aes_pkg::in_item_t'{'1, '1, 1'b0});
    drain();
    // Known FIPS-197 vector with a zero IV.
    setup(1'b0, 128'h000102030405060708090a0b0c0d0e0f, 128'h0);
    block_queue.push_back(aes_pkg::in_item_t'{64'h0011223344556677, 64'h8899aabbccddeeff,
                                              1'b1});
    block_queue.push_back(aes_pkg::in_item_t'{'1, '1, 1'b0});
    block_queue.push_back(aes_pkg::in_item_t'{64'h8000000000000001, 64'h0000000000000080,
                                              1'b0});
    drain();
    // All-ones key and IV; IV change only takes effect on a chain start.
    setup(1'b0, '1, '1);
    block_queue.push_back(aes_pkg::in_item_t'{64'h0, 64'h0, 1'b1});
    block_queue.push_back(rand_block(1'b0));
    drain();
    write_reg(aes_pkg::CfgIvLo, 64'h0123456789abcdef);
    block_queue.push_back(rand_block(1'b0));
    block_queue.push_back(rand_block(1'b1));
    drain();
    // Mode change within a chain, an ignored out-of-range index, decrypt extremes.
    write_reg(aes_pkg::CfgMode, 64'h1);
    write_reg(CfgBadIdx, '1);
    block_queue.push_back(aes_pkg::in_item_t'{'1, '1, 1'b0});
    block_queue.push_back(aes_pkg::in_item_t'{64'h0, 64'h0, 1'b0});
    block_queue.push_back(rand_block(1'b1));
    drain();
    write_reg(aes_pkg::CfgMode, 64'h0);
    block_queue.push_back(rand_block(1'b0));
    drain();

    // Random phases: well-formed chains with new settings between phases.
    for (int ph = 0; ph < 12; ph++) begin
      setup(1'($urandom_range(0, 1)), {$urandom, $urandom, $urandom, $urandom},
            {$urandom, $urandom, $urandom, $urandom});
      if (ph % 4 == 3) write_reg(aes_pkg::CfgKeyLo, {$urandom, $urandom});
      for (int n = 0; n < 75; n += len) begin
        len = $urandom_range(1, 12);
        for (int j = 0; j < len; j++)
          block_queue.push_back(rand_block(j == 0 ? 1'b1 : ($urandom_range(0, 15) == 0)));
      end
      if (ph == 5) begin
        // Long receiver hold-off while requests keep coming.
        hold_req = 1'b1;
        wait (hold_cycles != 0);
        hold_req = 1'b0;
      end
      drain();
    end

    $display("ran %0d blocks with %0d results and %0d register writes,", n_blocks,
             n_results, n_cfg);
    $display("both modes, restarted and continued chains, key and IV changes");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
